FILE: hdl/ackp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ackp_pkg
// Shared types and constants of the alpha statistics and color key picker.
// ----------------------------------------------------------------------------
package ackp_pkg;

   localparam int MAP_ADDR_W = 12;
   localparam int COUNT_W    = 21;
   localparam int N_W        = COUNT_W + 1;
   localparam int TOTAL_W    = 28;
   localparam int SQUARE_W   = 36;
   localparam int DIV_STEP_W = 6;

   typedef enum logic [1:0] {
      CSR_TRANSPARENT_BELOW = 2'd0,
      CSR_OPAQUE_ABOVE      = 2'd1,
      CSR_VARIANCE_LIMIT    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic       req_type;
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
      logic [7:0] pix_alpha;
      logic       last_pixel;
   } req_beat_type;

   typedef struct packed {
      logic       res_kind;
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       use_alpha_format;
      logic [7:0] key_red;
      logic [7:0] key_green;
      logic [7:0] key_blue;
      logic [7:0] mean_alpha;
      logic       apply_surface_alpha;
   } rsp_beat_type;

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_SETUP    = 8'b0000_0100,
      ST_DIV_MEAN = 8'b0000_1000,
      ST_DIV_MSQ  = 8'b0001_0000,
      ST_DECIDE   = 8'b0010_0000,
      ST_SCAN     = 8'b0100_0000,
      ST_REPORT   = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic idle;
      logic setup;
      logic cap_mean;
      logic cap_msq;
      logic decide;
      logic sweep;
      logic scan;
      logic report;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic sweep_end;
   } status_type;

endpackage

`default_nettype wire

FILE: hdl/ackp_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ackp_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module ackp_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           div_start,
   input  wire logic [ackp_pkg::SQUARE_W-1:0]  dividend,
   input  wire logic [ackp_pkg::N_W-1:0]       divisor,
   output logic                                div_done,
   output logic [ackp_pkg::SQUARE_W-1:0]       quotient
);
   import ackp_pkg::*;

   logic [SQUARE_W-1:0]   dvd_ff, dvd_in;
   logic [N_W-1:0]        rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DIV_STEP_W-1:0] cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [N_W:0]          trial;
   logic                  fits;

   // operand load on start, else one shift and subtract step
   always_comb begin
      trial  = {rem_ff, dvd_ff[SQUARE_W-1]};
      fits   = trial >= {1'b0, dsr_ff};
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (div_start) begin
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = DIV_STEP_W'(SQUARE_W);
      end else if (cnt_ff != '0) begin
         dvd_in  = {dvd_ff[SQUARE_W-2:0], fits};
         rem_in  = fits ? N_W'(trial - {1'b0, dsr_ff}) : trial[N_W-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = cnt_ff == DIV_STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign div_done = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

FILE: hdl/ackp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ackp_ctrl
// Sequencer for map clearing, statistics division, key search and summary.
// ----------------------------------------------------------------------------
module ackp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 last_accept,
   input  wire ackp_pkg::status_type status,
   output ackp_pkg::cmd_type         cmd,
   output logic                      busy
);
   import ackp_pkg::*;

   state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (status.sweep_end) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (last_accept) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            if (status.div_done) begin
               cmd.cap_mean = 1'b1;
               state_in     = ST_DIV_MSQ;
            end
         end
         ST_DIV_MSQ: begin
            if (status.div_done) begin
               cmd.cap_msq = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.sweep = 1'b1;
            cmd.scan  = 1'b1;
            if (status.sweep_end) state_in = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   assign busy = state_ff != ST_IDLE;

endmodule

`default_nettype wire

FILE: hdl/ackp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ackp_dp
// Counters, sums, color map, divider and result register.
// ----------------------------------------------------------------------------
module ackp_dp (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire ackp_pkg::req_beat_type req,
   input  wire logic                   csr_valid,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_data,
   input  wire ackp_pkg::cmd_type      cmd,
   output ackp_pkg::status_type        status,
   output logic                        rsp_valid,
   output ackp_pkg::rsp_beat_type      rsp
);
   import ackp_pkg::*;

   // configuration registers
   logic [7:0]  tr_below_ff, op_above_ff;
   logic [15:0] var_limit_ff;

   // pass statistics
   logic [COUNT_W-1:0]  tr_cnt_ff, op_cnt_ff, semi_cnt_ff;
   logic [TOTAL_W-1:0]  a_tot_ff;
   logic [SQUARE_W-1:0] a_sq_ff;

   // held summary
   logic [7:0]            held_mean_ff;
   logic [MAP_ADDR_W-1:0] held_key_ff;
   logic                  held_mode_ff;

   // summary work registers
   logic [7:0]            mean_ff;
   logic [SQUARE_W-1:0]   msq_ff;
   logic                  keep_ff;
   logic                  found_ff;
   logic [MAP_ADDR_W-1:0] key_ff;

   // color map sweep
   logic                  map_mem [2**MAP_ADDR_W];
   logic                  map_rd_ff;
   logic [MAP_ADDR_W-1:0] sweep_ff, rd_addr_ff;
   logic                  rd_valid_ff;

   logic                  rsp_valid_ff;
   rsp_beat_type          rsp_ff, rsp_in;

   logic                  accept, an_accept, cv_accept;
   logic [7:0]            a;
   logic [15:0]           a_sq;
   logic [TOTAL_W:0]      tot_sum;
   logic [SQUARE_W:0]     sq_sum;
   logic [N_W-1:0]        n;
   logic [N_W:0]          all_cnt;
   logic                  div_start, div_done;
   logic [SQUARE_W-1:0]   dividend, quotient;
   logic [15:0]           mean_sq;
   logic [SQUARE_W-1:0]   var_val;
   logic                  found_now, mode_now;
   logic [MAP_ADDR_W-1:0] key_now, map_idx;

   assign accept    = start && cmd.idle;
   assign an_accept = accept && !req.req_type;
   assign cv_accept = accept && req.req_type;
   assign a         = req.pix_alpha;
   assign a_sq      = 16'(a) * 16'(a);
   assign tot_sum   = {1'b0, a_tot_ff} + (TOTAL_W + 1)'(a);
   assign sq_sum    = {1'b0, a_sq_ff} + (SQUARE_W + 1)'(a_sq);
   assign n         = {1'b0, op_cnt_ff} + {1'b0, semi_cnt_ff};
   assign all_cnt   = {1'b0, n} + (N_W + 1)'(tr_cnt_ff);
   assign map_idx   = {req.pix_red[7:4], req.pix_green[7:4], req.pix_blue[7:4]};

   // divider shared by mean and mean square
   assign div_start = cmd.setup || cmd.cap_mean;
   assign dividend  = cmd.setup ? SQUARE_W'(a_tot_ff) : a_sq_ff;

   ackp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_start(div_start),
      .dividend (dividend),
      .divisor  (n),
      .div_done (div_done),
      .quotient (quotient)
   );

   assign status.div_done  = div_done;
   assign status.sweep_end = sweep_ff == {MAP_ADDR_W{1'b1}};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tr_below_ff  <= 8'd16;
         op_above_ff  <= 8'd240;
         var_limit_ff <= 16'd16;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TRANSPARENT_BELOW: tr_below_ff  <= csr_data[7:0];
            CSR_OPAQUE_ABOVE:      op_above_ff  <= csr_data[7:0];
            CSR_VARIANCE_LIMIT:    var_limit_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // saturating counters and sums
   always_ff @(posedge clock) begin
      if (reset || cmd.report) begin
         tr_cnt_ff   <= '0;
         op_cnt_ff   <= '0;
         semi_cnt_ff <= '0;
         a_tot_ff    <= '0;
         a_sq_ff     <= '0;
      end else if (an_accept) begin
         if (a < tr_below_ff) begin
            if (~&tr_cnt_ff) tr_cnt_ff <= tr_cnt_ff + 1'b1;
         end else begin
            if (a > op_above_ff) begin
               if (~&op_cnt_ff) op_cnt_ff <= op_cnt_ff + 1'b1;
            end else begin
               if (~&semi_cnt_ff) semi_cnt_ff <= semi_cnt_ff + 1'b1;
            end
            a_tot_ff <= tot_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : tot_sum[TOTAL_W-1:0];
            a_sq_ff  <= sq_sum[SQUARE_W] ? {SQUARE_W{1'b1}} : sq_sum[SQUARE_W-1:0];
         end
      end
   end

   // color map: marks on analyse beats with nonzero alpha, zeroes on sweeps
   always_ff @(posedge clock) begin
      if (cmd.sweep) map_mem[sweep_ff] <= 1'b0;
      else if (an_accept && a != 8'd0) map_mem[map_idx] <= 1'b1;
      map_rd_ff  <= map_mem[sweep_ff];
      rd_addr_ff <= sweep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.sweep) sweep_ff <= sweep_ff + 1'b1;
         rd_valid_ff <= cmd.scan;
      end
   end

   // mean, variance and key search
   assign mean_sq   = 16'(mean_ff) * 16'(mean_ff);
   assign var_val   = msq_ff - SQUARE_W'(mean_sq);
   assign found_now = found_ff || (rd_valid_ff && !map_rd_ff);
   assign key_now   = found_ff ? key_ff : rd_addr_ff;
   assign mode_now  = keep_ff || !found_now;

   always_ff @(posedge clock) begin
      if (cmd.cap_mean) begin
         if (n == '0)                 mean_ff <= 8'd0;
         else if (|quotient[SQUARE_W-1:8]) mean_ff <= 8'hff;
         else                         mean_ff <= quotient[7:0];
      end
      if (cmd.cap_msq) msq_ff <= (n == '0) ? '0 : quotient;
      if (cmd.decide) begin
         keep_ff <= ((N_W + 1)'(semi_cnt_ff) > (all_cnt >> 3)) &&
                    (msq_ff > SQUARE_W'(mean_sq)) &&
                    (var_val > SQUARE_W'(var_limit_ff));
      end
      if (cmd.decide) found_ff <= 1'b0;
      else if (rd_valid_ff && !map_rd_ff && !found_ff) begin
         found_ff <= 1'b1;
         key_ff   <= rd_addr_ff;
      end
   end

   // held summary for the convert pass
   always_ff @(posedge clock) begin
      if (reset) begin
         held_mean_ff <= '0;
         held_key_ff  <= '0;
         held_mode_ff <= 1'b0;
      end else if (cmd.report) begin
         held_mean_ff <= mean_ff;
         held_mode_ff <= mode_now;
         held_key_ff  <= mode_now ? '0 : key_now;
      end
   end

   // result beat
   always_comb begin
      rsp_in = '0;
      if (cmd.report) begin
         rsp_in.use_alpha_format = mode_now;
         rsp_in.mean_alpha       = mean_ff;
         if (!mode_now) begin
            rsp_in.key_red   = {key_now[11:8], 4'hf};
            rsp_in.key_green = {key_now[7:4], 4'hf};
            rsp_in.key_blue  = {key_now[3:0], 4'hf};
            rsp_in.apply_surface_alpha = mean_ff < op_above_ff;
         end
      end else begin
         rsp_in.res_kind = 1'b1;
         if (!held_mode_ff && a < {2'b00, held_mean_ff[7:2]}) begin
            rsp_in.out_red   = {held_key_ff[11:8], 4'hf};
            rsp_in.out_green = {held_key_ff[7:4], 4'hf};
            rsp_in.out_blue  = {held_key_ff[3:0], 4'hf};
            rsp_in.out_alpha = 8'hff;
         end else begin
            rsp_in.out_red   = req.pix_red;
            rsp_in.out_green = req.pix_green;
            rsp_in.out_blue  = req.pix_blue;
            rsp_in.out_alpha = a;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= cv_accept || cmd.report;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

FILE: hdl/alpha_stats_color_key_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// alpha_stats_color_key_picker
// Two-pass alpha statistics, color key choice and key substitution.
// ----------------------------------------------------------------------------
// convert beat result is registered and valid in the cycle after accept
// throughput: one beat per cycle, except the last analyse beat, which holds
//   busy through two 36-step divisions and then a 4096-entry map sweep that
//   finds the key and clears the map; the summary beat follows the sweep
// reset: busy while the color map is cleared; csr always ready
// results carry no back-pressure: the receiver must take each rsp_valid beat
module alpha_stats_color_key_picker (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire ackp_pkg::req_beat_type req,
   output logic                        rsp_valid,
   output ackp_pkg::rsp_beat_type      rsp,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [15:0]            csr_data
);
   import ackp_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       last_accept;

   assign last_accept = start && !busy && !req.req_type && req.last_pixel;
   assign csr_ready   = 1'b1;

   ackp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .last_accept(last_accept),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   ackp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_valid(rsp_valid),
      .rsp      (rsp)
   );

   // last analyse beat starts the summary sequence
   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      last_accept |=> busy)
      else $error("last analyse beat did not raise busy");

   // convert beat gives a converted pixel next cycle
   a_convert_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.req_type) |=> (rsp_valid && rsp.res_kind))
      else $error("convert beat lost");

   // summary only at the end of a busy sequence
   a_summary_src: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp.res_kind) |-> $past(busy))
      else $error("summary without sequence");

endmodule

`default_nettype wire
